[rtl/core/mafh_pkg.sv]
// Package for the MPEG audio frame header checker.
// Holds header field codes, frame length scale factors and the bitrate and
// sample rate tables. No dependencies.
package mafh_pkg;

    // Version field codes
    localparam logic [1:0] VER_MPEG25   = 2'b00;
    localparam logic [1:0] VER_RESERVED = 2'b01;
    localparam logic [1:0] VER_MPEG2    = 2'b10;
    localparam logic [1:0] VER_MPEG1    = 2'b11;

    // Layer field codes
    localparam logic [1:0] LAYER_RESERVED = 2'b00;
    localparam logic [1:0] LAYER_III      = 2'b01;
    localparam logic [1:0] LAYER_II       = 2'b10;
    localparam logic [1:0] LAYER_I        = 2'b11;

    // Rejected index codes
    localparam logic [3:0] BR_FREE     = 4'd0;
    localparam logic [3:0] BR_BAD      = 4'd15;
    localparam logic [1:0] SR_RESERVED = 2'd3;

    // Widths
    localparam int KBPS_W  = 9;
    localparam int SCALE_W = 18;
    localparam int NUM_W   = 27;
    localparam int BASE_W  = 16;
    localparam int RECIP_Q = 40;
    localparam int RECIP_W = 26;
    localparam int QUO_W   = 12;
    localparam int LEN_W   = 12;

    // Frame length scale factors
    localparam logic [SCALE_W-1:0] L1_SCALE  = SCALE_W'(12000);
    localparam logic [SCALE_W-1:0] L23_SCALE = SCALE_W'(144000);

    // Base sample rates (MPEG-1), and fixed-point reciprocals floor(2^40 / rate)
    localparam int RATE0 = 44100;
    localparam int RATE1 = 48000;
    localparam int RATE2 = 32000;
    localparam logic [RECIP_W-1:0] RECIP0 = RECIP_W'((64'd1 << RECIP_Q) / RATE0);
    localparam logic [RECIP_W-1:0] RECIP1 = RECIP_W'((64'd1 << RECIP_Q) / RATE1);
    localparam logic [RECIP_W-1:0] RECIP2 = RECIP_W'((64'd1 << RECIP_Q) / RATE2);

    // Bitrate tables in kbit/s, indexed by bitrate index (entry 15 unused)
    typedef logic [KBPS_W-1:0] kbps_row_t [16];

    localparam kbps_row_t KBPS_V1_L1 = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam kbps_row_t KBPS_V1_L2 = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam kbps_row_t KBPS_V1_L3 = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam kbps_row_t KBPS_V2_L1 = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam kbps_row_t KBPS_V2_L23 = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    // Bitrate lookup by version class, layer code and bitrate index
    function automatic logic [KBPS_W-1:0] kbps_lookup(
        input logic       low_fs,
        input logic [1:0] layer,
        input logic [3:0] br
    );
        logic [KBPS_W-1:0] kbps;
        kbps = '0;
        if (low_fs)
        begin
            kbps = (layer == LAYER_I) ? KBPS_V2_L1[br] : KBPS_V2_L23[br];
        end
        else
        begin
            unique case (layer)
                LAYER_I:  kbps = KBPS_V1_L1[br];
                LAYER_II: kbps = KBPS_V1_L2[br];
                default:  kbps = KBPS_V1_L3[br];
            endcase
        end
        return kbps;
    endfunction

    // Base sample rate by sample rate index
    function automatic logic [BASE_W-1:0] base_rate(input logic [1:0] sr);
        logic [BASE_W-1:0] rate;
        unique case (sr)
            2'd0:    rate = BASE_W'(RATE0);
            2'd1:    rate = BASE_W'(RATE1);
            default: rate = BASE_W'(RATE2);
        endcase
        return rate;
    endfunction

    // Reciprocal of the base sample rate
    function automatic logic [RECIP_W-1:0] base_recip(input logic [1:0] sr);
        logic [RECIP_W-1:0] recip;
        unique case (sr)
            2'd0:    recip = RECIP0;
            2'd1:    recip = RECIP1;
            default: recip = RECIP2;
        endcase
        return recip;
    endfunction

endpackage

[rtl/core/mpeg_audio_frame_header_check.sv]
// MPEG audio frame header checker: validates a header word, computes frame length.
// Uses mafh_pkg for field codes, rate and bitrate tables.
//
// Usage:
//   Input channel: in_valid / in_ready with header_word (four header bytes,
//   first byte in bits 31..24). Output channel: out_valid / out_ready with
//   header_ok and frame_bytes (0 when the header is rejected).
//   Each header gives exactly one result, in order.
// Throughput: one header per cycle while out_ready does not hold the output.
//   Four register stages, in order: decode and table lookup, bitrate times
//   scale multiply, reciprocal multiply, remainder correction and length; the
//   last drives the outputs. Division by the sample rate is a multiply by a
//   fixed-point reciprocal plus one compare-and-subtract correction.
// Stalls: each stage holds while the stage after it is full and stalled;
//   in_ready stays high while any stage is empty, so the pipeline keeps
//   filling while a finished result waits on out_ready.
// Reset: rst_n clears all stage valid bits; no results are pending after it.
//   The block has no configuration and no state beyond the pipeline.
module mpeg_audio_frame_header_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] header_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        header_ok,
    output logic [11:0] frame_bytes
);

    // Stage valid bits and per-stage advance
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: field decode and checks
    logic       sync_ok;
    logic [1:0] ver;
    logic [1:0] lay;
    logic [3:0] br;
    logic [1:0] sr;
    logic       low_fs;
    logic       quarter;
    logic       ok_next;
    logic [1:0] shift_next;

    assign sync_ok = &header_word[31:21];
    assign ver     = header_word[20:19];
    assign lay     = header_word[18:17];
    assign br      = header_word[15:12];
    assign sr      = header_word[11:10];
    assign low_fs  = (ver != mafh_pkg::VER_MPEG1);
    assign quarter = (ver == mafh_pkg::VER_MPEG25);
    assign ok_next = sync_ok && (ver != mafh_pkg::VER_RESERVED)
                  && (lay != mafh_pkg::LAYER_RESERVED)
                  && (br != mafh_pkg::BR_FREE) && (br != mafh_pkg::BR_BAD)
                  && (sr != mafh_pkg::SR_RESERVED);
    // Sample rate is base >> (low_fs + quarter); layer III low-fs doubles it back
    assign shift_next = (lay == mafh_pkg::LAYER_III) ? {1'b0, quarter}
                                                     : {1'b0, low_fs} + {1'b0, quarter};

    logic                        ok1_reg;
    logic                        l1_1_reg;
    logic                        pad1_reg;
    logic [1:0]                  shift1_reg;
    logic [1:0]                  sr1_reg;
    logic [mafh_pkg::KBPS_W-1:0] kbps1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            ok1_reg    <= ok_next;
            l1_1_reg   <= (lay == mafh_pkg::LAYER_I);
            pad1_reg   <= header_word[9];
            shift1_reg <= shift_next;
            sr1_reg    <= sr;
            // Rejected headers carry a zero bitrate so the arithmetic stays at zero
            kbps1_reg  <= ok_next ? mafh_pkg::kbps_lookup(low_fs, lay, br) : '0;
        end
    end

    // Stage 2: numerator = kbps * scale << shift
    logic [mafh_pkg::SCALE_W-1:0] scale;
    logic [mafh_pkg::NUM_W-1:0]   prod2;
    logic [mafh_pkg::NUM_W-1:0]   num_next;

    assign scale    = l1_1_reg ? mafh_pkg::L1_SCALE : mafh_pkg::L23_SCALE;
    assign prod2    = mafh_pkg::NUM_W'(kbps1_reg) * mafh_pkg::NUM_W'(scale);
    assign num_next = prod2 << shift1_reg;

    logic                       ok2_reg;
    logic                       l1_2_reg;
    logic                       pad2_reg;
    logic [1:0]                 sr2_reg;
    logic [mafh_pkg::NUM_W-1:0] num2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            ok2_reg  <= ok1_reg;
            l1_2_reg <= l1_1_reg;
            pad2_reg <= pad1_reg;
            sr2_reg  <= sr1_reg;
            num2_reg <= num_next;
        end
    end

    // Stage 3: quotient estimate via reciprocal multiply (low by at most one)
    logic [mafh_pkg::NUM_W+mafh_pkg::RECIP_W-1:0] prod3;
    logic [mafh_pkg::QUO_W-1:0]                   qest_next;

    assign prod3     = num2_reg * mafh_pkg::base_recip(sr2_reg);
    assign qest_next = prod3[mafh_pkg::RECIP_Q +: mafh_pkg::QUO_W];

    logic                       ok3_reg;
    logic                       l1_3_reg;
    logic                       pad3_reg;
    logic [1:0]                 sr3_reg;
    logic [mafh_pkg::NUM_W-1:0] num3_reg;
    logic [mafh_pkg::QUO_W-1:0] qest3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (rdy3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            ok3_reg   <= ok2_reg;
            l1_3_reg  <= l1_2_reg;
            pad3_reg  <= pad2_reg;
            sr3_reg   <= sr2_reg;
            num3_reg  <= num2_reg;
            qest3_reg <= qest_next;
        end
    end

    // Stage 4: remainder check, correction, padding and layer I slot scaling
    logic [mafh_pkg::BASE_W-1:0] base3;
    logic [mafh_pkg::NUM_W-1:0]  qb;
    logic [mafh_pkg::NUM_W-1:0]  rem;
    logic                        corr;
    logic [mafh_pkg::LEN_W-1:0]  quo;
    logic [mafh_pkg::LEN_W-1:0]  slots;
    logic [mafh_pkg::LEN_W-1:0]  len_next;

    assign base3    = mafh_pkg::base_rate(sr3_reg);
    assign qb       = mafh_pkg::NUM_W'(qest3_reg) * mafh_pkg::NUM_W'(base3);
    assign rem      = num3_reg - qb;
    assign corr     = (rem >= mafh_pkg::NUM_W'(base3));
    assign quo      = qest3_reg + mafh_pkg::LEN_W'(corr);
    assign slots    = quo + mafh_pkg::LEN_W'(pad3_reg);
    assign len_next = !ok3_reg ? '0 : (l1_3_reg ? (slots << 2) : slots);

    logic                       ok4_reg;
    logic [mafh_pkg::LEN_W-1:0] len4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (rdy4)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            ok4_reg  <= ok3_reg;
            len4_reg <= len_next;
        end
    end

    assign out_valid   = v4_reg;
    assign header_ok   = ok4_reg;
    assign frame_bytes = len4_reg;

`ifndef NO_ASSERTIONS
    // A rejected header reports zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !header_ok |-> frame_bytes == '0)
        else $error("rejected header with nonzero length");

    // A usable header always has a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_ok |-> frame_bytes != '0)
        else $error("usable header with zero length");

    // Reciprocal estimate is never more than one below the true quotient
    assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (num3_reg >= qb)
                   && (rem < (mafh_pkg::NUM_W'(base3) << 1)))
        else $error("quotient estimate out of correction range");

    // An input transfer always lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted header lost at stage 1");

    // A held result is not dropped while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_bytes))
        else $error("stalled result changed");
`endif

endmodule
